// ----- rtl/core/ilcp_pkg.sv -----
// ----------------------------------------------------------------------------
// ilcp_pkg
// Shared constants, state encoding and unit status type for the isosurface
// link crossing point generator.
// ----------------------------------------------------------------------------
package ilcp_pkg;

	localparam int GRID_SIZE = 64;
	localparam int COORD_W   = $clog2(GRID_SIZE);
	localparam int ADDR_W    = 3 * COORD_W;
	localparam int DEPTH     = GRID_SIZE * GRID_SIZE * GRID_SIZE;
	localparam int SAMPLE_W  = 18;
	localparam int VAL_W     = 16;
	localparam int POINT_W   = 32;
	localparam int SQ_W      = 32;
	localparam int ROOT_W    = SQ_W / 2;
	localparam int DEN_W     = SAMPLE_W + 1;
	localparam int NUM_W     = VAL_W + 8 + SAMPLE_W;
	localparam int QUO_W     = VAL_W + 8;
	localparam int BASE_W    = VAL_W + COORD_W + 2 + 8;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic CFG_LEVEL = 1'b0;
	localparam logic CFG_SCALE = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SUM,
		ST_ROOT,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_MASK,
		ST_AXIS,
		ST_DIVGO,
		ST_DIVIDE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

// ----- rtl/core/isosurface_link_crossing_points.sv -----
// ----------------------------------------------------------------------------
// isosurface_link_crossing_points
// Grid of field magnitudes with per-voxel link crossing interpolation.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken when start is high and busy is low. func 0 loads one grid
// sample: the magnitude of (comp_re, comp_im) minus level_threshold is
// written to the grid memory. func 1 queries a voxel: its +x, +y and +z
// links are tested and one result is strobed on result_valid for each
// crossed link, in axis order, the final one with last_point set.
// A load keeps busy high through squaring, summing, the square-root unit
// (sixteen steps and its done cycle) and one write. A query makes four reads
// through the single memory port and the sign test, then runs the bit-serial
// divider (42 steps) that forms the interpolation fraction once per crossed
// link. Queries outside the interior give no result and return at once.
// Registers are written on the cfg channel (always ready); the user must
// write them only while idle, which the block itself does not enforce. Reset
// clears the control state and sets the registers to threshold 0 and scale
// 1.0; the grid memory holds nothing until loaded. Results are strobed for
// one cycle each; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module isosurface_link_crossing_points
	import ilcp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      func,
	input  logic [COORD_W-1:0]        grid_x,
	input  logic [COORD_W-1:0]        grid_y,
	input  logic [COORD_W-1:0]        grid_z,
	input  logic signed [VAL_W-1:0]   comp_re,
	input  logic signed [VAL_W-1:0]   comp_im,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [VAL_W-1:0]          cfg_data,
	output logic                      result_valid,
	output logic [1:0]                link_axis,
	output logic signed [POINT_W-1:0] point_x,
	output logic signed [POINT_W-1:0] point_y,
	output logic signed [POINT_W-1:0] point_z,
	output logic                      last_point
);

	function automatic logic signed [POINT_W-1:0] sat_point(
		input logic signed [BASE_W:0] v
	);
		logic [BASE_W-POINT_W+1:0] hi;
		hi = v[BASE_W:POINT_W-1];
		if (hi == '0 || hi == '1) begin
			return v[POINT_W-1:0];
		end else if (v[BASE_W]) begin
			return {1'b1, {(POINT_W-1){1'b0}}};
		end else begin
			return {1'b0, {(POINT_W-1){1'b1}}};
		end
	endfunction

	state_t state_q, state_d;

	logic accept;
	logic load_in_grid;
	logic query_inside;

	logic [COORD_W-1:0]      gx_q, gy_q, gz_q;
	logic signed [VAL_W-1:0] re_q, im_q;
	logic [SQ_W-1:0]         sq_re_q, sq_im_q;
	logic [VAL_W-1:0]        level_q, scale_q;

	logic [SAMPLE_W-1:0] grid_mem [0:DEPTH-1];
	logic [SAMPLE_W-1:0] rdata_q;
	logic [SAMPLE_W-1:0] wdata;
	logic [ADDR_W-1:0]   mem_addr;
	logic                mem_we;

	logic [1:0] rd_cnt_q;
	logic       rd_pend_s1;
	logic [1:0] rd_sel_s1;

	logic signed [SAMPLE_W-1:0] f_q [0:3];
	logic signed [BASE_W-1:0]   base_q [0:2];
	logic [2:0]                 crossed;
	logic [2:0]                 mask_q;
	logic [1:0]                 axis_sel;
	logic [1:0]                 axis_q;
	logic [SAMPLE_W-1:0]        a0, a1;
	logic signed [SAMPLE_W-1:0] f_end;
	logic [NUM_W-1:0]           num_q;
	logic [DEN_W-1:0]           den_q;
	logic                       zero_q;
	logic [QUO_W-1:0]           off;

	logic         sqrt_start, div_start;
	unit_status_t sqrt_status, div_status;
	logic [ROOT_W-1:0] root;
	logic [NUM_W-1:0]  quotient;

	logic                      result_valid_q, last_q;
	logic [1:0]                link_axis_q;
	logic signed [POINT_W-1:0] pt_q [0:2];
	logic                      emit;

	assign accept       = start && (state_q == ST_IDLE);
	assign load_in_grid = ({1'b0, grid_x} < (COORD_W+1)'(GRID_SIZE)) &&
		({1'b0, grid_y} < (COORD_W+1)'(GRID_SIZE)) &&
		({1'b0, grid_z} < (COORD_W+1)'(GRID_SIZE));
	assign query_inside = ({1'b0, grid_x} < (COORD_W+1)'(GRID_SIZE - 1)) &&
		({1'b0, grid_y} < (COORD_W+1)'(GRID_SIZE - 1)) &&
		({1'b0, grid_z} < (COORD_W+1)'(GRID_SIZE - 1));
	assign emit = (state_q == ST_DIVIDE) && div_status.done;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (func == FUNC_LOAD) begin
						state_d = load_in_grid ? ST_SQUARE : ST_IDLE;
					end else begin
						state_d = query_inside ? ST_READ : ST_IDLE;
					end
				end
			end
			ST_SQUARE: state_d = ST_SUM;
			ST_SUM:    state_d = ST_ROOT;
			ST_ROOT: begin
				if (sqrt_status.done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_READ: begin
				if (rd_cnt_q == 2'd3) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_MASK;
			ST_MASK:  state_d = ST_AXIS;
			ST_AXIS:  state_d = (mask_q == 3'b000) ? ST_IDLE : ST_DIVGO;
			ST_DIVGO: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (div_status.done) begin
					state_d = ST_AXIS;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy       = (state_q != ST_IDLE);
		sqrt_start = (state_q == ST_SUM);
		div_start  = (state_q == ST_DIVGO);
		mem_we     = (state_q == ST_WRITE);
	end

	always_comb begin
		case (rd_cnt_q)
			2'd1:    mem_addr = {COORD_W'(gx_q + 1'b1), gy_q, gz_q};
			2'd2:    mem_addr = {gx_q, COORD_W'(gy_q + 1'b1), gz_q};
			2'd3:    mem_addr = {gx_q, gy_q, COORD_W'(gz_q + 1'b1)};
			default: mem_addr = {gx_q, gy_q, gz_q};
		endcase
	end

	assign wdata = SAMPLE_W'($signed({2'b00, root}) - $signed({2'b00, level_q}));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_addr] <= wdata;
		end
		rdata_q <= grid_mem[mem_addr];
	end

	// link is crossed when the product of its end values is not positive
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			crossed[k] = (f_q[0] == '0) || (f_q[k+1] == '0) ||
				(f_q[0][SAMPLE_W-1] != f_q[k+1][SAMPLE_W-1]);
		end
		if (mask_q[0]) begin
			axis_sel = AXIS_X;
		end else if (mask_q[1]) begin
			axis_sel = AXIS_Y;
		end else begin
			axis_sel = AXIS_Z;
		end
		case (axis_sel)
			AXIS_X:  f_end = f_q[1];
			AXIS_Y:  f_end = f_q[2];
			default: f_end = f_q[3];
		endcase
		a0  = f_q[0][SAMPLE_W-1] ? SAMPLE_W'(-f_q[0]) : f_q[0];
		a1  = f_end[SAMPLE_W-1] ? SAMPLE_W'(-f_end) : f_end;
		off = zero_q ? '0 : quotient[QUO_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rd_cnt_q       <= '0;
			rd_pend_s1     <= 1'b0;
			mask_q         <= '0;
			result_valid_q <= 1'b0;
			level_q        <= '0;
			scale_q        <= VAL_W'(256);
		end else begin
			state_q        <= state_d;
			rd_pend_s1     <= (state_q == ST_READ);
			result_valid_q <= emit;
			if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end else begin
				rd_cnt_q <= '0;
			end
			if (state_q == ST_MASK) begin
				mask_q <= crossed;
			end else if (emit) begin
				mask_q[axis_q] <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_LEVEL: level_q <= cfg_data;
					CFG_SCALE: scale_q <= cfg_data;
					default:   level_q <= level_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gx_q <= grid_x;
			gy_q <= grid_y;
			gz_q <= grid_z;
			re_q <= comp_re;
			im_q <= comp_im;
		end
		if (state_q == ST_SQUARE) begin
			sq_re_q <= $unsigned(SQ_W'(re_q) * SQ_W'(re_q));
			sq_im_q <= $unsigned(SQ_W'(im_q) * SQ_W'(im_q));
		end
		rd_sel_s1 <= rd_cnt_q;
		if (rd_pend_s1) begin
			f_q[rd_sel_s1] <= rdata_q;
		end
		if (state_q == ST_DRAIN) begin
			base_q[0] <= (BASE_W'($signed({1'b0, scale_q})) *
				BASE_W'($signed({1'b0, gx_q}) - (COORD_W+1)'(GRID_SIZE/2))) <<< 8;
			base_q[1] <= (BASE_W'($signed({1'b0, scale_q})) *
				BASE_W'($signed({1'b0, gy_q}) - (COORD_W+1)'(GRID_SIZE/2))) <<< 8;
			base_q[2] <= (BASE_W'($signed({1'b0, scale_q})) *
				BASE_W'($signed({1'b0, gz_q}) - (COORD_W+1)'(GRID_SIZE/2))) <<< 8;
		end
		if (state_q == ST_AXIS) begin
			axis_q <= axis_sel;
			num_q  <= NUM_W'({scale_q, 8'd0}) * NUM_W'(a0);
			den_q  <= DEN_W'({1'b0, a0} + {1'b0, a1});
			zero_q <= (a0 == '0) && (a1 == '0);
		end
		if (emit) begin
			link_axis_q <= axis_q;
			last_q      <= ((mask_q & ~(3'b001 << axis_q)) == 3'b000);
			for (int j = 0; j < 3; j++) begin
				if (axis_q == 2'(j)) begin
					pt_q[j] <= sat_point((BASE_W+1)'(base_q[j]) +
						$signed({1'b0, (BASE_W)'(off)}));
				end else begin
					pt_q[j] <= sat_point((BASE_W+1)'(base_q[j]));
				end
			end
		end
	end

	ilcp_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand (sq_re_q + sq_im_q),
		.status  (sqrt_status),
		.root    (root)
	);

	ilcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (den_q),
		.status   (div_status),
		.quotient (quotient)
	);

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign link_axis    = link_axis_q;
	assign point_x      = pt_q[0];
	assign point_y      = pt_q[1];
	assign point_z      = pt_q[2];
	assign last_point   = last_q;

endmodule

// ----- rtl/core/ilcp_isqrt.sv -----
// ----------------------------------------------------------------------------
// ilcp_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ilcp_isqrt
	import ilcp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   operand,
	output unit_status_t      status,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;
	logic            busy_q;
	logic            done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= operand;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign root        = res_q[ROOT_W-1:0];

endmodule

// ----- rtl/core/ilcp_div.sv -----
// ----------------------------------------------------------------------------
// ilcp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ilcp_div
	import ilcp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output unit_status_t     status,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   shifted;
	logic             take;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign take    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[NUM_W-2:0], take};
			if (take) begin
				rem_q <= DEN_W'(shifted - {1'b0, den_q});
			end else begin
				rem_q <= shifted[DEN_W-1:0];
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

// ----- rtl/core/ilcp_checker.sv -----
// ----------------------------------------------------------------------------
// ilcp_checker
// Port-level checks for the isosurface link crossing point generator.
// ----------------------------------------------------------------------------
module ilcp_checker
	import ilcp_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      func,
	input logic [COORD_W-1:0]        grid_x,
	input logic [COORD_W-1:0]        grid_y,
	input logic [COORD_W-1:0]        grid_z,
	input logic signed [VAL_W-1:0]   comp_re,
	input logic signed [VAL_W-1:0]   comp_im,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic                      cfg_index,
	input logic [VAL_W-1:0]          cfg_data,
	input logic                      result_valid,
	input logic [1:0]                link_axis,
	input logic signed [POINT_W-1:0] point_x,
	input logic signed [POINT_W-1:0] point_y,
	input logic signed [POINT_W-1:0] point_z,
	input logic                      last_point
);

	// results come only from a query still in progress
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside a query");

	// divider spacing keeps results apart
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("results back to back");

	a_axis_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (link_axis == AXIS_X || link_axis == AXIS_Y ||
			link_axis == AXIS_Z)) else $error("bad link axis");

	// a load always occupies the block
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_LOAD) |=> busy)
		else $error("load not taken up");

endmodule

bind isosurface_link_crossing_points ilcp_checker u_ilcp_checker (.*);
